@@ hdl/aab_pkg.sv @@
package aab_pkg;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned PIX_W     = 32;
    localparam int unsigned ALPHA_LSB = 24;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;
    localparam logic [17:0]     DIV2   = 18'd65025;
    localparam logic [17:0]     DIV2X2 = 18'd130050;

    // register indexes of the configuration port
    localparam logic [0:0] REG_USE_LOOKUP   = 1'b0;
    localparam logic [0:0] REG_LOOKUP_ALPHA = 1'b1;

    // load enables of the three channel stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } aab_stage_en_t;

    // floor(x / 255), exact for x up to 65025
    function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        begin
            t = 17'(x) + 17'(x[15:8]) + 17'd1;
            return t[15:8];
        end
    endfunction

    function automatic logic [CH_W-1:0] sat8(input logic [9:0] x);
        begin
            return (x > 10'(CH_MAX)) ? CH_MAX : x[7:0];
        end
    endfunction

endpackage

@@ hdl/aab_chan.sv @@
module aab_chan
    import aab_pkg::*;
(
    input  logic          aclk,
    input  aab_stage_en_t en,
    input  logic [7:0]    fg_in,
    input  logic [7:0]    bg_in,
    input  logic [7:0]    a1_in,
    input  logic [7:0]    la_in,
    input  logic [15:0]   k_s1,
    input  logic          use_lookup,
    output logic [7:0]    chan_out
);

    // stage 1: byte products
    logic [7:0]  fg1_reg;
    logic [7:0]  bg1_reg;
    logic [15:0] pfg1_reg;
    logic [15:0] plk1_reg;
    logic [15:0] pfg1_next;
    logic [15:0] plk1_next;

    // stage 2: weight times background, first divisions
    logic [23:0] y2_reg;
    logic [7:0]  qfg2_reg;
    logic [8:0]  lk2_reg;
    logic [23:0] y2_next;
    logic [7:0]  qfg2_next;
    logic [8:0]  lk2_next;

    // stage 3: estimated quotient and remainder of the divide by 65025
    logic [7:0]  q03_reg;
    logic [17:0] rem3_reg;
    logic [7:0]  qfg3_reg;
    logic [8:0]  lk3_reg;
    logic [17:0] rem3_next;

    logic [8:0]  q3;
    logic [9:0]  ex3;

    assign pfg1_next = 16'(a1_in) * 16'(fg_in);
    assign plk1_next = 16'(la_in) * 16'(bg_in);

    assign y2_next   = 24'(k_s1) * 24'(bg1_reg);
    assign qfg2_next = div255(pfg1_reg);
    assign lk2_next  = 9'(fg1_reg) + 9'(div255(plk1_reg));

    // y>>16 underestimates floor(y/65025) by at most two
    assign rem3_next = 18'(y2_reg[15:0]) + {1'b0, y2_reg[23:16], 9'b0} - 18'(y2_reg[23:16]);

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            fg1_reg  <= fg_in;
            bg1_reg  <= bg_in;
            pfg1_reg <= pfg1_next;
            plk1_reg <= plk1_next;
        end
        if (en.s2) begin
            y2_reg   <= y2_next;
            qfg2_reg <= qfg2_next;
            lk2_reg  <= lk2_next;
        end
        if (en.s3) begin
            q03_reg  <= y2_reg[23:16];
            rem3_reg <= rem3_next;
            qfg3_reg <= qfg2_reg;
            lk3_reg  <= lk2_reg;
        end
    end

    assign q3  = 9'(q03_reg) + 9'(rem3_reg >= DIV2) + 9'(rem3_reg >= DIV2X2);
    assign ex3 = 10'(qfg3_reg) + 10'(q3);

    assign chan_out = use_lookup ? sat8(10'(lk3_reg)) : sat8(ex3);

endmodule

@@ hdl/argb_alpha_blend.sv @@
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_src_pixel, s_dst_pixel, s_last_in
// m_        out        m_valid / m_ready  m_result_pixel, m_write_enable, m_last_out
// cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// four register stages; a new word is taken every cycle while the output is not stalled,
// with one 8x8 product, one 16x8 product and the divide-by-65025 remainder step
// each holding a stage of their own.
// reset (aresetn, synchronous) empties the pipeline and clears both registers.
// each stage holds while the one after it is full and stalled, so bubbles fill.
module argb_alpha_blend
    import aab_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_src_pixel,
    input  logic [31:0] s_dst_pixel,
    input  logic        s_last_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_pixel,
    output logic        m_write_enable,
    output logic        m_last_out
);

    logic        use_lookup_reg;
    logic [7:0]  lookup_alpha_reg;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        en1, en2, en3, en4;
    aab_stage_en_t chan_en;

    logic [31:0] src1_reg, src2_reg, src3_reg;
    logic [31:0] dst1_reg, dst2_reg, dst3_reg;
    logic        last1_reg, last2_reg, last3_reg;
    logic [15:0] k1_reg;
    logic [7:0]  a1_1_reg, a1_2_reg;
    logic [7:0]  kd2_reg;
    logic [8:0]  na3_reg;

    logic [7:0]  sa0;
    logic [7:0]  a1_0;
    logic [7:0]  a2_0;
    logic [15:0] k1_next;
    logic [8:0]  na3_next;

    logic [31:0] result_reg;
    logic        we_reg;
    logic        last_reg;
    logic [31:0] result_next;
    logic        we_next;

    logic [7:0]  chan3 [3];
    logic [7:0]  sa3;
    logic [7:0]  alpha3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_lookup_reg   <= 1'b0;
            lookup_alpha_reg <= 8'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_USE_LOOKUP:   use_lookup_reg   <= cfg_wdata[0];
                REG_LOOKUP_ALPHA: lookup_alpha_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or the next stage takes its word
    assign en4 = !v4_reg || m_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;

    assign chan_en = '{s1: en1, s2: en2, s3: en3};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    assign sa0     = s_src_pixel[31:24];
    assign a1_0    = ~s_src_pixel[31:24];
    assign a2_0    = ~s_dst_pixel[31:24];
    assign k1_next = 16'(sa0) * 16'(a2_0);
    assign na3_next = 9'(a1_2_reg) + 9'(kd2_reg);

    always_ff @(posedge aclk) begin
        if (en1) begin
            src1_reg  <= s_src_pixel;
            dst1_reg  <= s_dst_pixel;
            last1_reg <= s_last_in;
            k1_reg    <= k1_next;
            a1_1_reg  <= a1_0;
        end
        if (en2) begin
            src2_reg  <= src1_reg;
            dst2_reg  <= dst1_reg;
            last2_reg <= last1_reg;
            a1_2_reg  <= a1_1_reg;
            kd2_reg   <= div255(k1_reg);
        end
        if (en3) begin
            src3_reg  <= src2_reg;
            dst3_reg  <= dst2_reg;
            last3_reg <= last2_reg;
            na3_reg   <= na3_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++) begin : g_chan
            aab_chan u_chan (
                .aclk       (aclk),
                .en         (chan_en),
                .fg_in      (s_src_pixel[gi*CH_W +: CH_W]),
                .bg_in      (s_dst_pixel[gi*CH_W +: CH_W]),
                .a1_in      (a1_0),
                .la_in      (lookup_alpha_reg),
                .k_s1       (k1_reg),
                .use_lookup (use_lookup_reg),
                .chan_out   (chan3[gi])
            );
        end
    endgenerate

    assign sa3 = src3_reg[31:24];
    assign alpha3 = use_lookup_reg ? 8'd0 : (CH_MAX - sat8(10'(na3_reg)));

    always_comb begin
        if (sa3 == 8'd0) begin
            result_next = src3_reg;
            we_next     = 1'b1;
        end else if (sa3 == CH_MAX) begin
            result_next = dst3_reg;
            we_next     = 1'b0;
        end else begin
            result_next = {alpha3, chan3[2], chan3[1], chan3[0]};
            we_next     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            result_reg <= result_next;
            we_reg     <= we_next;
            last_reg   <= last3_reg;
        end
    end

    assign m_valid        = v4_reg;
    assign m_result_pixel = result_reg;
    assign m_write_enable = we_reg;
    assign m_last_out     = last_reg;

`ifndef SYNTHESIS
    // a full stage behind a stalled output keeps its word
    a_stage3_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !m_ready && v3_reg) |=> (v3_reg && $stable(src3_reg) && $stable(na3_reg)))
        else $error("stage 3 word lost under output stall");

    // accepted word reaches stage 1
    a_accept_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted word not in stage 1");

    // exact-mode coverage never exceeds full
    a_alpha_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (na3_reg <= 9'(CH_MAX)))
        else $error("blend alpha out of range");
`endif

endmodule

@@ tb/blend_checker.sv @@
`timescale 1ns / 100ps

module blend_checker
    import aab_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_src_pixel,
    input  logic [31:0] s_dst_pixel,
    input  logic        s_last_in,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_result_pixel,
    input  logic        m_write_enable,
    input  logic        m_last_out,

    output int          mismatch_count,
    output int          pending_words
);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             wr;
        logic             last;
    } blend_word_t;

    blend_word_t blended_q[$];
    blend_word_t exp_w;
    logic        lookup_mode;
    logic [7:0]  lookup_alpha;

    function automatic blend_word_t predict_blend(input logic [31:0] src,
                                                  input logic [31:0] dst,
                                                  input logic last,
                                                  input logic add_mode,
                                                  input logic [7:0] la);
        blend_word_t w;
        int unsigned sa, a1, a2, k, fg, bg, c, na;
        int ch;
        w.last  = last;
        w.pixel = '0;
        sa = src[31:24];
        if (sa == 0) begin
            w.pixel = src;
            w.wr    = 1'b1;
        end else if (sa == 255) begin
            w.pixel = dst;
            w.wr    = 1'b0;
        end else begin
            w.wr = 1'b1;
            a1 = 255 - sa;
            a2 = 255 - dst[31:24];
            k  = sa * a2;
            for (ch = 0; ch < 3; ch++) begin
                fg = src[8*ch +: 8];
                bg = dst[8*ch +: 8];
                if (add_mode)
                    c = fg + (la * bg) / 255;
                else
                    c = (a1 * fg) / 255 + (k * bg) / 65025;
                if (c > 255)
                    c = 255;
                w.pixel[8*ch +: 8] = c[7:0];
            end
            if (add_mode) begin
                w.pixel[31:24] = 8'd0;
            end else begin
                na = a1 + k / 255;
                if (na > 255)
                    na = 255;
                w.pixel[31:24] = 8'(255 - na);
            end
        end
        return w;
    endfunction

    initial begin
        mismatch_count = 0;
        pending_words  = 0;
        lookup_mode    = 1'b0;
        lookup_alpha   = 8'd0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            blended_q.delete();
            lookup_mode  = 1'b0;
            lookup_alpha = 8'd0;
        end else begin
            if (m_valid && m_ready) begin
                if (blended_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected word pixel=%h we=%b last=%b", $realtime,
                                 m_result_pixel, m_write_enable, m_last_out);
                end else begin
                    exp_w = blended_q.pop_front();
                    if (exp_w.pixel !== m_result_pixel || exp_w.wr !== m_write_enable ||
                        exp_w.last !== m_last_out) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch pixel exp=%h got=%h we exp=%b got=%b %s",
                                     $realtime, exp_w.pixel, m_result_pixel, exp_w.wr,
                                     m_write_enable,
                                     $sformatf("last exp=%b got=%b", exp_w.last, m_last_out));
                    end
                end
            end
            if (s_valid && s_ready)
                blended_q.push_back(predict_blend(s_src_pixel, s_dst_pixel, s_last_in,
                                                  lookup_mode, lookup_alpha));
            // register writes must land only while the pipe is empty; nothing here enforces it
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_USE_LOOKUP:   lookup_mode  = cfg_wdata[0];
                    REG_LOOKUP_ALPHA: lookup_alpha = cfg_wdata;
                    default: ;
                endcase
            end
        end
        pending_words = blended_q.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top
    import aab_pkg::*;
();

    localparam int STALL_LIMIT = 3000;
    localparam int SEG_WORDS   = 100;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_src_pixel;
    logic [31:0] s_dst_pixel;
    logic        s_last_in;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_result_pixel;
    logic        m_write_enable;
    logic        m_last_out;

    int mismatch_count;
    int pending_words;
    int tx_idle_pct;
    int rx_idle_pct;
    int idle_cycles;
    int hold_left;
    logic hold_req;

    argb_alpha_blend DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_src_pixel    (s_src_pixel),
        .s_dst_pixel    (s_dst_pixel),
        .s_last_in      (s_last_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_pixel (m_result_pixel),
        .m_write_enable (m_write_enable),
        .m_last_out     (m_last_out)
    );

    blend_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_src_pixel    (s_src_pixel),
        .s_dst_pixel    (s_dst_pixel),
        .s_last_in      (s_last_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_pixel (m_result_pixel),
        .m_write_enable (m_write_enable),
        .m_last_out     (m_last_out),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random back-pressure plus one long hold-off on request
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = 300;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[argb_alpha_blend] ERROR");
                $finish;
            end
        end
    end

    // offer one word and hold it until taken; returns at a falling edge
    task automatic send_word(input logic [31:0] src, input logic [31:0] dst,
                             input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_src_pixel <= src;
        s_dst_pixel <= dst;
        s_last_in   <= last;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_pipe();
        wait (pending_words == 0);
        repeat (6) @(negedge aclk);
    endtask

    task automatic set_mode(input logic [7:0] mode_word, input logic [7:0] alpha);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_USE_LOOKUP;
        cfg_wdata <= mode_word;
        @(negedge aclk);
        cfg_index <= REG_LOOKUP_ALPHA;
        cfg_wdata <= alpha;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // alpha and channels lean toward the opaque, invisible and edge values
    function automatic logic [31:0] rand_pixel();
        logic [31:0] px;
        int ch;
        px = $urandom;
        case ($urandom_range(9))
            0, 1:    px[31:24] = 8'd0;
            2, 3:    px[31:24] = 8'd255;
            4:       px[31:24] = 8'd1;
            5:       px[31:24] = 8'd254;
            default: ;
        endcase
        for (ch = 0; ch < 3; ch++) begin
            case ($urandom_range(7))
                0:       px[8*ch +: 8] = 8'd0;
                1:       px[8*ch +: 8] = 8'd255;
                default: ;
            endcase
        end
        return px;
    endfunction

    initial begin
        int seg;
        int n;
        logic add_mode;
        logic [7:0] la;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_USE_LOOKUP;
        cfg_wdata   = 8'd0;
        s_valid     = 1'b0;
        s_src_pixel = '0;
        s_dst_pixel = '0;
        s_last_in   = 1'b0;
        hold_req    = 1'b0;
        tx_idle_pct = 12;
        rx_idle_pct = 71;
        idle_cycles = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // exact mode straight out of reset
        send_word(32'h00123456, 32'hFFABCDEF, 1'b0);   // opaque source
        send_word(32'hFF123456, 32'h00ABCDEF, 1'b1);   // invisible source
        send_word(32'h01FFFFFF, 32'h00FFFFFF, 1'b0);
        send_word(32'hFE000000, 32'h00FFFFFF, 1'b0);
        send_word(32'hFEFFFFFF, 32'hFFFFFFFF, 1'b0);
        send_word(32'h80FF00FF, 32'hFF00FF00, 1'b1);
        send_word(32'h7F123456, 32'h00ABCDEF, 1'b0);
        send_word(32'h00000000, 32'hFFFFFFFF, 1'b0);
        send_word(32'hFFFFFFFF, 32'h00000000, 1'b1);
        send_word(32'h01000000, 32'hFF000000, 1'b0);
        send_word(32'h40FFFFFF, 32'h40FFFFFF, 1'b0);
        send_word(32'hC0010203, 32'h01FEFDFC, 1'b1);
        s_valid <= 1'b0;
        drain_pipe();

        // lookup mode, upper mode bits set to check they are dropped
        set_mode(8'hFF, 8'd255);
        send_word(32'h01FFFFFF, 32'h00FFFFFF, 1'b0);   // saturates
        send_word(32'h80000000, 32'hFFFFFFFF, 1'b0);
        send_word(32'hFE102030, 32'h00FFFFFF, 1'b1);
        send_word(32'h00ABCDEF, 32'h12345678, 1'b0);
        send_word(32'hFFFFFFFF, 32'h00000000, 1'b1);
        send_word(32'h40808080, 32'h7F808080, 1'b0);
        send_word(32'h01000000, 32'h00000000, 1'b0);
        s_valid <= 1'b0;
        drain_pipe();

        for (seg = 0; seg < 8; seg++) begin
            if (seg < 3) begin
                tx_idle_pct = 12;
                rx_idle_pct = 71;
            end else if (seg < 6) begin
                tx_idle_pct = 71;
                rx_idle_pct = 12;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            add_mode = (seg == 1 || seg == 2 || seg == 4 || seg == 6);
            case (seg)
                1:       la = 8'd0;
                2:       la = 8'd255;
                default: la = 8'($urandom);
            endcase
            set_mode({7'($urandom), add_mode}, la);
            for (n = 0; n < SEG_WORDS; n++) begin
                if (seg == 6 && n == 30)
                    hold_req = 1'b1;
                send_word(rand_pixel(), rand_pixel(), 1'($urandom));
            end
            s_valid <= 1'b0;
            drain_pipe();
        end

        wait (pending_words == 0);
        repeat (12) @(posedge aclk);
        if (mismatch_count == 0 && pending_words == 0)
            $display("[argb_alpha_blend] OK");
        else
            $display("[argb_alpha_blend] ERROR");
        $finish;
    end

endmodule
